FILE: design/kems_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// kems_pkg
// Shared types and constants for the key event matrix scanner.
// ----------------------------------------------------------------------------
package kems_pkg;

    localparam int HELD_SLOTS     = 16;
    localparam int MATRIX_ROWS    = 8;
    localparam int HOST_KEY_CODES = 256;

    localparam int KEY_W   = 8;
    localparam int MASK_W  = 8;
    localparam int ROW_W   = 3;
    localparam int SCAN_W  = 4;
    localparam int DATA_W  = 8;
    localparam int OP_W    = 3;
    localparam int CFG_IW  = 3;

    // Table: one entry per (host key, host shift) pair
    localparam int TBL_AW    = KEY_W + 1;
    localparam int TBL_DEPTH = 1 << TBL_AW;
    localparam int TBL_W     = 1 + ROW_W + MASK_W + 1;

    // Held list
    localparam int HELD_W  = KEY_W + 1;
    localparam int HELD_IW = (HELD_SLOTS > 1) ? $clog2(HELD_SLOTS) : 1;
    localparam int HELD_CW = $clog2(HELD_SLOTS + 1);

    localparam int ROW_IW  = (MATRIX_ROWS > 1) ? $clog2(MATRIX_ROWS) : 1;

    localparam logic [SCAN_W-1:0] SCAN_NONE = SCAN_W'(8);
    localparam logic [DATA_W-1:0] READ_NONE = 8'hFF;

    typedef enum logic [OP_W-1:0] {
        OP_LOAD      = 3'd0,
        OP_CLEAR     = 3'd1,
        OP_PRESS     = 3'd2,
        OP_RELEASE   = 3'd3,
        OP_ROW_WRITE = 3'd4,
        OP_READ      = 3'd5
    } op_t;

    typedef enum logic [CFG_IW-1:0] {
        CFG_LEFT_SHIFT  = 3'd0,
        CFG_RIGHT_SHIFT = 3'd1,
        CFG_ALTGR       = 3'd2,
        CFG_SHIFT_ROW   = 3'd3,
        CFG_SHIFT_MASK  = 3'd4
    } cfg_idx_t;

    typedef enum logic [3:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_P_LOOK,
        ST_P_SET,
        ST_R_CMP,
        ST_R_TBL,
        ST_R_SHF,
        ST_R_MOVE,
        ST_FINISH
    } state_t;

    // Read-modify-write request to the key matrix
    typedef struct packed {
        logic              we;
        logic [ROW_W-1:0]  row;
        logic [MASK_W-1:0] mask;
        logic              set;
    } drive_t;

    typedef struct packed {
        logic              valid;
        logic [ROW_W-1:0]  row;
        logic [MASK_W-1:0] mask;
        logic              tshift;
    } tbl_entry_t;

endpackage : kems_pkg
`default_nettype wire

FILE: design/key_event_matrix_scanner.sv
`timescale 1ns / 1ps
`default_nettype none
// Sequence: load, row write, read and unused ops go from idle straight to the result
//   stage; a press reads the key table, drives the forced shift, then sets the columns;
//   a release searches the held list record by record, clears the columns, restores
//   shift and moves later records up; clear map sweeps the whole key table first.
// Flow: a transaction is taken only in idle, reached once the result register is loaded.
// Reset: a clearing pass over the whole key table runs before s_ready rises.
// ----------------------------------------------------------------------------
// key_event_matrix_scanner
// Maps host key events onto an 8-row key matrix read by a scanning processor.
// ----------------------------------------------------------------------------
module key_event_matrix_scanner (
    input  wire logic                            aclk,
    input  wire logic                            aresetn,
    // input channel
    input  wire logic                            s_valid,
    output logic                                 s_ready,
    input  wire logic [kems_pkg::OP_W-1:0]       s_op,
    input  wire logic [kems_pkg::KEY_W-1:0]      s_host_key,
    input  wire logic                            s_host_shift,
    input  wire logic [kems_pkg::ROW_W-1:0]      s_matrix_row,
    input  wire logic [kems_pkg::MASK_W-1:0]     s_matrix_col_mask,
    input  wire logic                            s_target_shift,
    input  wire logic [kems_pkg::DATA_W-1:0]     s_bus_data,
    // result channel
    output logic                                 m_valid,
    input  wire logic                            m_ready,
    output logic      [kems_pkg::DATA_W-1:0]     m_read_data,
    output logic                                 m_entry_found,
    output logic                                 m_list_full,
    // configuration
    input  wire logic                            cfg_wr_en,
    input  wire logic [kems_pkg::CFG_IW-1:0]     cfg_index,
    input  wire logic [kems_pkg::DATA_W-1:0]     cfg_wr_data
);
    import kems_pkg::*;

    // ---------------- configuration ----------------
    logic [KEY_W-1:0]  lshift_code_reg;
    logic [KEY_W-1:0]  rshift_code_reg;
    logic [KEY_W-1:0]  altgr_code_reg;
    logic [ROW_W-1:0]  shift_row_reg;
    logic [MASK_W-1:0] shift_mask_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            lshift_code_reg <= KEY_W'(0);
            rshift_code_reg <= KEY_W'(1);
            altgr_code_reg  <= KEY_W'(2);
            shift_row_reg   <= ROW_W'(0);
            shift_mask_reg  <= MASK_W'(1);
        end else if (cfg_wr_en) begin
            unique case (cfg_idx_t'(cfg_index))
                CFG_LEFT_SHIFT:  lshift_code_reg <= cfg_wr_data;
                CFG_RIGHT_SHIFT: rshift_code_reg <= cfg_wr_data;
                CFG_ALTGR:       altgr_code_reg  <= cfg_wr_data;
                CFG_SHIFT_ROW:   shift_row_reg   <= cfg_wr_data[ROW_W-1:0];
                CFG_SHIFT_MASK:  shift_mask_reg  <= cfg_wr_data;
                default: ;
            endcase
        end
    end

    // ---------------- key table memory ----------------
    logic [TBL_W-1:0]  tbl_mem [TBL_DEPTH];
    logic              tbl_we;
    logic [TBL_AW-1:0] tbl_waddr;
    logic [TBL_W-1:0]  tbl_wdata;
    logic              tbl_re;
    logic [TBL_AW-1:0] tbl_raddr;
    logic [TBL_W-1:0]  tbl_q;
    tbl_entry_t        tbl_ent;

    always_ff @(posedge aclk) begin
        if (tbl_we) begin
            tbl_mem[tbl_waddr] <= tbl_wdata;
        end
        if (tbl_re) begin
            tbl_q <= tbl_mem[tbl_raddr];
        end
    end

    assign tbl_ent = tbl_entry_t'(tbl_q);

    // ---------------- held list memory ----------------
    logic [HELD_W-1:0]  held_mem [HELD_SLOTS];
    logic               held_we;
    logic [HELD_IW-1:0] held_waddr;
    logic [HELD_W-1:0]  held_wdata;
    logic               held_re;
    logic [HELD_IW-1:0] held_raddr;
    logic [HELD_W-1:0]  held_q;

    always_ff @(posedge aclk) begin
        if (held_we) begin
            held_mem[held_waddr] <= held_wdata;
        end
        if (held_re) begin
            held_q <= held_mem[held_raddr];
        end
    end

    // ---------------- key matrix ----------------
    drive_t            drv;
    logic [DATA_W-1:0] scan_data;
    logic [SCAN_W-1:0] scan_row_reg, scan_row_next;

    kems_matrix u_matrix (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .drv       (drv),
        .scan_row  (scan_row_reg),
        .scan_data (scan_data)
    );

    // ---------------- sequencer ----------------
    state_t             state_reg, state_next;
    logic [TBL_AW-1:0]  sweep_reg, sweep_next;
    logic               clr_post_reg, clr_post_next;
    logic               shift_held_reg, shift_held_next;
    logic [HELD_CW-1:0] held_count_reg, held_count_next;
    logic [HELD_CW-1:0] idx_reg, idx_next;
    logic [KEY_W-1:0]   key_reg, key_next;
    logic [DATA_W-1:0]  res_rd_reg, res_rd_next;
    logic               res_found_reg, res_found_next;
    logic               res_full_reg, res_full_next;
    logic               m_valid_reg, m_valid_next;
    logic [DATA_W-1:0]  m_rd_reg, m_rd_next;
    logic               m_found_reg, m_found_next;
    logic               m_full_reg, m_full_next;

    logic               accept;
    logic               key_ok;
    logic               is_shift_code;
    logic [SCAN_W-1:0]  row_enc;
    logic [HELD_CW:0]   idx_p1;
    logic [HELD_CW:0]   idx_p2;
    logic [HELD_CW:0]   count_x;

    assign s_ready = (state_reg == ST_IDLE);
    assign accept  = s_valid && s_ready;
    assign key_ok  = ({1'b0, s_host_key} < (KEY_W + 1)'(HOST_KEY_CODES));
    assign is_shift_code = (s_host_key == lshift_code_reg) ||
                           (s_host_key == rshift_code_reg);
    assign idx_p1  = {1'b0, idx_reg} + (HELD_CW + 1)'(1);
    assign idx_p2  = {1'b0, idx_reg} + (HELD_CW + 1)'(2);
    assign count_x = {1'b0, held_count_reg};

    // lowest zero bit selects the row
    always_comb begin
        row_enc = SCAN_NONE;
        for (int i = DATA_W - 1; i >= 0; i--) begin
            if (!s_bus_data[i]) begin
                row_enc = SCAN_W'(i);
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg      <= ST_CLEAR;
            sweep_reg      <= '0;
            clr_post_reg   <= 1'b0;
            shift_held_reg <= 1'b0;
            held_count_reg <= '0;
            idx_reg        <= '0;
            scan_row_reg   <= SCAN_NONE;
            m_valid_reg    <= 1'b0;
        end else begin
            state_reg      <= state_next;
            sweep_reg      <= sweep_next;
            clr_post_reg   <= clr_post_next;
            shift_held_reg <= shift_held_next;
            held_count_reg <= held_count_next;
            idx_reg        <= idx_next;
            scan_row_reg   <= scan_row_next;
            m_valid_reg    <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        key_reg       <= key_next;
        res_rd_reg    <= res_rd_next;
        res_found_reg <= res_found_next;
        res_full_reg  <= res_full_next;
        m_rd_reg      <= m_rd_next;
        m_found_reg   <= m_found_next;
        m_full_reg    <= m_full_next;
    end

    always_comb begin
        state_next      = state_reg;
        sweep_next      = sweep_reg;
        clr_post_next   = clr_post_reg;
        shift_held_next = shift_held_reg;
        held_count_next = held_count_reg;
        idx_next        = idx_reg;
        scan_row_next   = scan_row_reg;
        key_next        = key_reg;
        res_rd_next     = res_rd_reg;
        res_found_next  = res_found_reg;
        res_full_next   = res_full_reg;
        m_valid_next    = m_valid_reg && !m_ready;
        m_rd_next       = m_rd_reg;
        m_found_next    = m_found_reg;
        m_full_next     = m_full_reg;

        tbl_we     = 1'b0;
        tbl_waddr  = sweep_reg;
        tbl_wdata  = '0;
        tbl_re     = 1'b0;
        tbl_raddr  = {s_host_key, shift_held_reg};
        held_we    = 1'b0;
        held_waddr = held_count_reg[HELD_IW-1:0];
        held_wdata = {key_reg, shift_held_reg};
        held_re    = 1'b0;
        held_raddr = idx_reg[HELD_IW-1:0];
        drv.we     = 1'b0;
        drv.row    = shift_row_reg;
        drv.mask   = shift_mask_reg;
        drv.set    = 1'b0;

        unique case (state_reg)
            ST_CLEAR: begin
                tbl_we = 1'b1;
                sweep_next = sweep_reg + TBL_AW'(1);
                if (sweep_reg == TBL_AW'(TBL_DEPTH - 1)) begin
                    state_next = clr_post_reg ? ST_FINISH : ST_IDLE;
                end
            end

            ST_IDLE: begin
                if (accept) begin
                    key_next       = s_host_key;
                    res_rd_next    = '0;
                    res_found_next = 1'b0;
                    res_full_next  = 1'b0;
                    state_next     = ST_FINISH;
                    unique case (s_op)
                        OP_LOAD: begin
                            if (key_ok) begin
                                tbl_we    = 1'b1;
                                tbl_waddr = {s_host_key, s_host_shift};
                                tbl_wdata = {1'b1, s_matrix_row, s_matrix_col_mask,
                                             s_target_shift};
                            end
                        end
                        OP_CLEAR: begin
                            sweep_next    = '0;
                            clr_post_next = 1'b1;
                            state_next    = ST_CLEAR;
                        end
                        OP_PRESS: begin
                            if (is_shift_code) begin
                                shift_held_next = 1'b1;
                                drv.we  = 1'b1;
                                drv.set = 1'b1;
                            end else if (key_ok) begin
                                tbl_re     = 1'b1;
                                state_next = ST_P_LOOK;
                            end
                        end
                        OP_RELEASE: begin
                            if (is_shift_code) begin
                                shift_held_next = 1'b0;
                                drv.we  = 1'b1;
                                drv.set = 1'b0;
                            end else if (s_host_key != altgr_code_reg &&
                                         held_count_reg != '0) begin
                                idx_next   = '0;
                                held_re    = 1'b1;
                                held_raddr = '0;
                                state_next = ST_R_CMP;
                            end
                        end
                        OP_ROW_WRITE: begin
                            scan_row_next = row_enc;
                        end
                        OP_READ: begin
                            res_rd_next = scan_data;
                        end
                        default: ;
                    endcase
                end
            end

            ST_P_LOOK: begin
                if (tbl_ent.valid) begin
                    res_found_next = 1'b1;
                    // forced shift first, entry columns in the next cycle
                    drv.we  = 1'b1;
                    drv.set = tbl_ent.tshift;
                    if (held_count_reg < HELD_CW'(HELD_SLOTS)) begin
                        held_we         = 1'b1;
                        held_count_next = held_count_reg + HELD_CW'(1);
                    end else begin
                        res_full_next = 1'b1;
                    end
                    state_next = ST_P_SET;
                end else begin
                    state_next = ST_FINISH;
                end
            end

            ST_P_SET: begin
                drv.we     = 1'b1;
                drv.row    = tbl_ent.row;
                drv.mask   = tbl_ent.mask;
                drv.set    = 1'b1;
                state_next = ST_FINISH;
            end

            ST_R_CMP: begin
                if (held_q[HELD_W-1:1] == key_reg) begin
                    tbl_re     = 1'b1;
                    tbl_raddr  = held_q;
                    state_next = ST_R_TBL;
                end else if (idx_p1 < count_x) begin
                    idx_next   = idx_p1[HELD_CW-1:0];
                    held_re    = 1'b1;
                    held_raddr = idx_p1[HELD_IW-1:0];
                end else begin
                    state_next = ST_FINISH;
                end
            end

            ST_R_TBL: begin
                if (tbl_ent.valid) begin
                    res_found_next = 1'b1;
                    drv.we     = 1'b1;
                    drv.row    = tbl_ent.row;
                    drv.mask   = tbl_ent.mask;
                    drv.set    = 1'b0;
                    state_next = ST_R_SHF;
                end else begin
                    // stale record stays in the list
                    state_next = ST_FINISH;
                end
            end

            ST_R_SHF: begin
                drv.we  = 1'b1;
                drv.set = shift_held_reg;
                if (idx_p1 < count_x) begin
                    held_re    = 1'b1;
                    held_raddr = idx_p1[HELD_IW-1:0];
                    state_next = ST_R_MOVE;
                end else begin
                    held_count_next = held_count_reg - HELD_CW'(1);
                    state_next      = ST_FINISH;
                end
            end

            ST_R_MOVE: begin
                // close the gap: entry idx+1 moves to idx
                held_we    = 1'b1;
                held_waddr = idx_reg[HELD_IW-1:0];
                held_wdata = held_q;
                idx_next   = idx_p1[HELD_CW-1:0];
                if (idx_p2 < count_x) begin
                    held_re    = 1'b1;
                    held_raddr = idx_p2[HELD_IW-1:0];
                end else begin
                    held_count_next = held_count_reg - HELD_CW'(1);
                    state_next      = ST_FINISH;
                end
            end

            ST_FINISH: begin
                if (!m_valid_reg || m_ready) begin
                    m_valid_next  = 1'b1;
                    m_rd_next     = res_rd_reg;
                    m_found_next  = res_found_reg;
                    m_full_next   = res_full_reg;
                    clr_post_next = 1'b0;
                    state_next    = ST_IDLE;
                end
            end

            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    assign m_valid       = m_valid_reg;
    assign m_read_data   = m_rd_reg;
    assign m_entry_found = m_found_reg;
    assign m_list_full   = m_full_reg;

endmodule : key_event_matrix_scanner
`default_nettype wire

FILE: design/kems_matrix.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// kems_matrix
// Key matrix bank: applies set/clear drives and serves the scan row read.
// ----------------------------------------------------------------------------
module kems_matrix (
    input  wire logic                          aclk,
    input  wire logic                          aresetn,
    input  wire kems_pkg::drive_t              drv,
    input  wire logic [kems_pkg::SCAN_W-1:0]   scan_row,
    output logic      [kems_pkg::DATA_W-1:0]   scan_data
);
    import kems_pkg::*;

    logic [MASK_W-1:0] mtx_reg [MATRIX_ROWS];
    logic [MASK_W-1:0] old_row;
    logic [MASK_W-1:0] new_row;
    logic              drv_ok;
    logic              scan_ok;

    assign drv_ok  = drv.we && ({1'b0, drv.row} < SCAN_W'(MATRIX_ROWS));
    assign scan_ok = (scan_row < SCAN_W'(MATRIX_ROWS));

    always_comb begin
        old_row = mtx_reg[drv.row[ROW_IW-1:0]];
        if (drv.set) begin
            new_row = old_row | drv.mask;
        end else begin
            new_row = old_row & ~drv.mask;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            for (int i = 0; i < MATRIX_ROWS; i++) begin
                mtx_reg[i] <= '0;
            end
        end else if (drv_ok) begin
            mtx_reg[drv.row[ROW_IW-1:0]] <= new_row;
        end
    end

    // columns are active low towards the processor
    always_comb begin
        if (scan_ok) begin
            scan_data = ~mtx_reg[scan_row[ROW_IW-1:0]];
        end else begin
            scan_data = READ_NONE;
        end
    end

endmodule : kems_matrix
`default_nettype wire

FILE: dv/kems_tb_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// kems_tb_pkg
// Transaction types and scoreboard for the key event matrix scanner bench.
// The scoreboard keeps its own copy of the key table, matrix, scan row and
// held list, and predicts one result per accepted transaction.
// ----------------------------------------------------------------------------
package kems_tb_pkg;
    import kems_pkg::*;

    // op codes the block must ignore
    localparam logic [OP_W-1:0] OP_SPARE_6 = 3'd6;
    localparam logic [OP_W-1:0] OP_SPARE_7 = 3'd7;

    typedef struct packed {
        logic [OP_W-1:0]   op;
        logic [KEY_W-1:0]  key;
        logic              host_shift;
        logic [ROW_W-1:0]  row;
        logic [MASK_W-1:0] mask;
        logic              tshift;
        logic [DATA_W-1:0] bus;
    } key_event_t;

    typedef struct packed {
        logic [DATA_W-1:0] read_data;
        logic              found;
        logic              full;
    } scan_result_t;

    typedef struct packed {
        logic [KEY_W-1:0]  left_shift;
        logic [KEY_W-1:0]  right_shift;
        logic [KEY_W-1:0]  altgr;
        logic [ROW_W-1:0]  shift_row;
        logic [MASK_W-1:0] shift_mask;
    } scanner_cfg_t;

    class matrix_scoreboard;
        scanner_cfg_t      cfg;
        tbl_entry_t        keymap [TBL_DEPTH];
        logic [MASK_W-1:0] matrix [MATRIX_ROWS];
        logic [SCAN_W-1:0] scan_row;
        logic              shift_on;
        logic [HELD_W-1:0] held [HELD_SLOTS];
        int                held_n;
        scan_result_t      expected_results [$];
        int                accepted;
        int                checked;
        int                errors;
        int                n_found;
        int                n_full;
        int                n_reads;

        function new();
            cfg = '{left_shift: 8'd0, right_shift: 8'd1, altgr: 8'd2,
                    shift_row: 3'd0, shift_mask: 8'd1};
            foreach (keymap[i]) keymap[i] = '0;
            foreach (matrix[i]) matrix[i] = '0;
            foreach (held[i]) held[i] = '0;
            scan_row = SCAN_NONE;
            shift_on = 1'b0;
            held_n   = 0;
            accepted = 0;
            checked  = 0;
            errors   = 0;
            n_found  = 0;
            n_full   = 0;
            n_reads  = 0;
        endfunction

        function void set_config(cfg_idx_t idx, logic [DATA_W-1:0] value);
            case (idx)
                CFG_LEFT_SHIFT:  cfg.left_shift  = value;
                CFG_RIGHT_SHIFT: cfg.right_shift = value;
                CFG_ALTGR:       cfg.altgr       = value;
                CFG_SHIFT_ROW:   cfg.shift_row   = value[ROW_W-1:0];
                CFG_SHIFT_MASK:  cfg.shift_mask  = value;
                default: ;
            endcase
        endfunction

        function void drive_matrix(logic [ROW_W-1:0] row, logic [MASK_W-1:0] mask,
                                   logic set);
            if (int'(row) < MATRIX_ROWS) begin
                if (set)
                    matrix[row] = matrix[row] | mask;
                else
                    matrix[row] = matrix[row] & ~mask;
            end
        endfunction

        // Work out the result of one accepted transaction and queue it
        function void note_event(key_event_t ev);
            scan_result_t      r;
            tbl_entry_t        e;
            logic [HELD_W-1:0] pair;
            int                slot;

            r = '0;
            accepted++;
            case (ev.op)
                OP_LOAD: begin
                    keymap[{ev.key, ev.host_shift}] =
                        '{valid: 1'b1, row: ev.row, mask: ev.mask, tshift: ev.tshift};
                end
                OP_CLEAR: begin
                    foreach (keymap[i]) keymap[i] = '0;
                end
                OP_PRESS: begin
                    if (ev.key == cfg.left_shift || ev.key == cfg.right_shift) begin
                        shift_on = 1'b1;
                        drive_matrix(cfg.shift_row, cfg.shift_mask, 1'b1);
                    end else begin
                        pair = {ev.key, shift_on};
                        e = keymap[pair];
                        if (e.valid) begin
                            r.found = 1'b1;
                            drive_matrix(cfg.shift_row, cfg.shift_mask, e.tshift);
                            drive_matrix(e.row, e.mask, 1'b1);
                            if (held_n < HELD_SLOTS) begin
                                held[held_n] = pair;
                                held_n++;
                            end else begin
                                r.full = 1'b1;
                            end
                        end
                    end
                end
                OP_RELEASE: begin
                    if (ev.key == cfg.left_shift || ev.key == cfg.right_shift) begin
                        shift_on = 1'b0;
                        drive_matrix(cfg.shift_row, cfg.shift_mask, 1'b0);
                    end else if (ev.key != cfg.altgr) begin
                        slot = -1;
                        for (int i = 0; i < held_n; i++)
                            if (slot < 0 && held[i][HELD_W-1:1] == ev.key)
                                slot = i;
                        // a record whose table entry has gone stale stays put
                        if (slot >= 0 && keymap[held[slot]].valid) begin
                            e = keymap[held[slot]];
                            r.found = 1'b1;
                            drive_matrix(e.row, e.mask, 1'b0);
                            drive_matrix(cfg.shift_row, cfg.shift_mask, shift_on);
                            for (int j = slot; j + 1 < held_n; j++)
                                held[j] = held[j + 1];
                            held_n--;
                        end
                    end
                end
                OP_ROW_WRITE: begin
                    // lowest zero bit wins
                    scan_row = SCAN_NONE;
                    for (int i = 7; i >= 0; i--)
                        if (!ev.bus[i])
                            scan_row = SCAN_W'(i);
                end
                OP_READ: begin
                    if (scan_row < SCAN_W'(MATRIX_ROWS))
                        r.read_data = ~matrix[scan_row[ROW_W-1:0]];
                    else
                        r.read_data = READ_NONE;
                end
                default: ;
            endcase
            expected_results.insert(expected_results.size(), r);
        endfunction

        function void check_result(scan_result_t got);
            scan_result_t want;

            if (expected_results.size() == 0) begin
                $display("%0t: result with nothing expected: read_data %02h found %0b full %0b",
                         $time, got.read_data, got.found, got.full);
                errors++;
                return;
            end
            want = expected_results.pop_front();
            checked++;
            if (want.found) n_found++;
            if (want.full)  n_full++;
            if (want.read_data != '0) n_reads++;
            if (got.read_data !== want.read_data) begin
                $display("%0t: read_data mismatch, expected %02h, got %02h",
                         $time, want.read_data, got.read_data);
                errors++;
            end
            if (got.found !== want.found) begin
                $display("%0t: entry_found mismatch, expected %0b, got %0b",
                         $time, want.found, got.found);
                errors++;
            end
            if (got.full !== want.full) begin
                $display("%0t: list_full mismatch, expected %0b, got %0b",
                         $time, want.full, got.full);
                errors++;
            end
        endfunction
    endclass

endpackage : kems_tb_pkg

FILE: dv/tb_key_event_matrix_scanner.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_key_event_matrix_scanner
// Self-checking bench for the key event matrix scanner. A directed opener hits
// table loads, presses, releases, shift and AltGr handling, stale records and
// row select edge cases; random key sessions then run under several register
// settings and idle/stall patterns, every result checked against a scoreboard.
// ----------------------------------------------------------------------------
module tb_key_event_matrix_scanner;
    import kems_pkg::*;
    import kems_tb_pkg::*;

    localparam int N_PHASES        = 6;
    localparam int PHASE_ITEMS     = 290;
    localparam int POOL_N          = 10;
    localparam int HOLD_OFF_CYCLES = 300;
    localparam int SETTLE_CYCLES   = 4;
    localparam int WATCHDOG_LIMIT  = 4000;

    logic                aclk;
    logic                aresetn;
    logic                s_valid;
    logic                s_ready;
    logic [OP_W-1:0]     s_op;
    logic [KEY_W-1:0]    s_host_key;
    logic                s_host_shift;
    logic [ROW_W-1:0]    s_matrix_row;
    logic [MASK_W-1:0]   s_matrix_col_mask;
    logic                s_target_shift;
    logic [DATA_W-1:0]   s_bus_data;
    logic                m_valid;
    logic                m_ready;
    logic [DATA_W-1:0]   m_read_data;
    logic                m_entry_found;
    logic                m_list_full;
    logic                cfg_wr_en;
    logic [CFG_IW-1:0]   cfg_index;
    logic [DATA_W-1:0]   cfg_wr_data;

    matrix_scoreboard    sb = new();
    key_event_t          stim_q [$];
    logic [KEY_W-1:0]    key_pool [POOL_N];
    int                  tx_idle_pct  = 0;
    int                  rx_stall_pct = 0;
    logic                rx_hold_req  = 1'b0;

    key_event_matrix_scanner dut (
        .aclk              (aclk),
        .aresetn           (aresetn),
        .s_valid           (s_valid),
        .s_ready           (s_ready),
        .s_op              (s_op),
        .s_host_key        (s_host_key),
        .s_host_shift      (s_host_shift),
        .s_matrix_row      (s_matrix_row),
        .s_matrix_col_mask (s_matrix_col_mask),
        .s_target_shift    (s_target_shift),
        .s_bus_data        (s_bus_data),
        .m_valid           (m_valid),
        .m_ready           (m_ready),
        .m_read_data       (m_read_data),
        .m_entry_found     (m_entry_found),
        .m_list_full       (m_list_full),
        .cfg_wr_en         (cfg_wr_en),
        .cfg_index         (cfg_index),
        .cfg_wr_data       (cfg_wr_data)
    );

    initial begin
        aclk = 1'b0;
        forever #5 aclk = ~aclk;
    end

    // Result side: random stalls, plus one long hold-off on request
    initial begin
        m_ready = 1'b0;
        forever begin
            @(posedge aclk);
            if (rx_hold_req) begin
                m_ready <= 1'b0;
                repeat (HOLD_OFF_CYCLES) @(posedge aclk);
                rx_hold_req = 1'b0;
            end
            m_ready <= ($urandom_range(0, 99) >= rx_stall_pct);
        end
    end

    // Transaction monitor: results are checked before the new input is noted
    always @(posedge aclk) begin
        if (aresetn) begin
            if (m_valid && m_ready)
                sb.check_result('{m_read_data, m_entry_found, m_list_full});
            if (s_valid && s_ready)
                sb.note_event('{s_op, s_host_key, s_host_shift, s_matrix_row,
                                s_matrix_col_mask, s_target_shift, s_bus_data});
        end
    end

    initial begin : watchdog
        int stalled;
        stalled = 0;
        while (stalled < WATCHDOG_LIMIT) begin
            @(posedge aclk);
            if ((s_valid && s_ready) || (m_valid && m_ready))
                stalled = 0;
            else
                stalled++;
        end
        $display("%0t: no transaction for %0d cycles", $time, WATCHDOG_LIMIT);
        $display("TEST FAILED");
        $finish;
    end

    // Append one transaction to the stimulus list
    function automatic void queue_event(input key_event_t e);
        stim_q.insert(stim_q.size(), e);
    endfunction

    // Don't-care fields are randomised
    function automatic key_event_t any_event(input logic [OP_W-1:0] op);
        key_event_t e;
        e = key_event_t'($urandom);
        e.op = op;
        return e;
    endfunction

    function automatic key_event_t key_event(input logic [OP_W-1:0] op,
                                             input logic [KEY_W-1:0] k);
        key_event_t e;
        e = any_event(op);
        e.key = k;
        return e;
    endfunction

    function automatic key_event_t load_event(input logic [KEY_W-1:0] k, input logic hs,
                                              input logic [ROW_W-1:0] row,
                                              input logic [MASK_W-1:0] mask,
                                              input logic ts);
        key_event_t e;
        e = key_event(OP_LOAD, k);
        e.host_shift = hs;
        e.row        = row;
        e.mask       = mask;
        e.tshift     = ts;
        return e;
    endfunction

    function automatic key_event_t row_event(input logic [DATA_W-1:0] bus);
        key_event_t e;
        e = any_event(OP_ROW_WRITE);
        e.bus = bus;
        return e;
    endfunction

    function automatic scanner_cfg_t phase_setting(input int p);
        scanner_cfg_t c;
        c = '{left_shift: 8'($urandom), right_shift: 8'($urandom), altgr: 8'($urandom),
              shift_row: 3'($urandom), shift_mask: 8'($urandom)};
        case (p)
            0: c = '{8'h00, 8'hFF, 8'h80, 3'd7, 8'hFF};
            1: c = '{8'h12, 8'h12, 8'h12, 3'd0, 8'h00};  // shift codes equal AltGr
            2: c = '{8'hFF, 8'h00, 8'hFF, 3'd3, 8'h01};
            4: c = '{8'hA5, 8'h5A, 8'h00, 3'd5, 8'h80};
            default: ;
        endcase
        return c;
    endfunction

    // Offer one transaction, idling first if the phase asks for it
    task automatic send_event(input key_event_t e);
        while (tx_idle_pct != 0 && $urandom_range(0, 99) < tx_idle_pct) begin
            s_valid <= 1'b0;
            @(posedge aclk);
        end
        s_valid           <= 1'b1;
        s_op              <= e.op;
        s_host_key        <= e.key;
        s_host_shift      <= e.host_shift;
        s_matrix_row      <= e.row;
        s_matrix_col_mask <= e.mask;
        s_target_shift    <= e.tshift;
        s_bus_data        <= e.bus;
        @(posedge aclk);
        while (!s_ready) @(posedge aclk);
    endtask

    task automatic drain_results();
        s_valid <= 1'b0;
        @(posedge aclk);
        while (sb.expected_results.size() != 0) @(posedge aclk);
        repeat (SETTLE_CYCLES) @(posedge aclk);
    endtask

    task automatic apply_config(input scanner_cfg_t c);
        logic [DATA_W-1:0] vals [5];
        vals = '{c.left_shift, c.right_shift, c.altgr, DATA_W'(c.shift_row), c.shift_mask};
        for (int i = 0; i < 5; i++) begin
            cfg_wr_en   <= 1'b1;
            cfg_index   <= CFG_IW'(i);
            cfg_wr_data <= vals[i];
            @(posedge aclk);
            sb.set_config(cfg_idx_t'(i), vals[i]);
        end
        cfg_wr_en <= 1'b0;
    endtask

    // One random key session step: mostly mapped-key traffic from a small pool
    task automatic queue_random_burst();
        int               pick;
        logic [KEY_W-1:0] k;
        logic [DATA_W-1:0] bus;
        logic [OP_W-1:0]  op;

        pick = $urandom_range(0, 99);
        k    = key_pool[$urandom_range(0, POOL_N - 1)];
        if (pick < 20) begin
            queue_event(load_event(k, 1'($urandom), 3'($urandom), 8'($urandom),
                                   1'($urandom)));
        end else if (pick < 45) begin
            queue_event(key_event(OP_PRESS, k));
        end else if (pick < 64) begin
            queue_event(key_event(OP_RELEASE, k));
        end else if (pick < 72) begin
            op = $urandom_range(0, 1) ? OP_PRESS : OP_RELEASE;
            queue_event(key_event(op, $urandom_range(0, 1) ? sb.cfg.left_shift
                                                            : sb.cfg.right_shift));
        end else if (pick < 74) begin
            queue_event(key_event(OP_RELEASE, sb.cfg.altgr));
        end else if (pick < 88) begin
            case ($urandom_range(0, 5))
                0, 1, 2: bus = ~(8'h01 << $urandom_range(0, 7));
                3, 4:    bus = 8'($urandom);
                default: bus = 8'hFF;
            endcase
            queue_event(row_event(bus));
            queue_event(any_event(OP_READ));
        end else if (pick < 93) begin
            queue_event(any_event(OP_READ));
        end else if (pick < 97) begin
            // unrelated keys and fields
            op = 3'($urandom_range(0, 5));
            if (op == OP_CLEAR)
                op = OP_PRESS;
            queue_event(any_event(op));
        end else if (pick < 98) begin
            queue_event(any_event($urandom_range(0, 1) ? OP_SPARE_6 : OP_SPARE_7));
        end else if (pick < 99) begin
            queue_event(any_event(OP_CLEAR));
        end else begin
            // flood one key so the held list overflows
            queue_event(load_event(k, 1'b0, 3'($urandom), 8'($urandom), 1'($urandom)));
            queue_event(load_event(k, 1'b1, 3'($urandom), 8'($urandom), 1'($urandom)));
            repeat (HELD_SLOTS + 1) queue_event(key_event(OP_PRESS, k));
        end
    endtask

    initial begin
        int phase_sent;

        aresetn           = 1'b0;
        s_valid           = 1'b0;
        s_op              = OP_READ;
        s_host_key        = '0;
        s_host_shift      = 1'b0;
        s_matrix_row      = '0;
        s_matrix_col_mask = '0;
        s_target_shift    = 1'b0;
        s_bus_data        = '0;
        cfg_wr_en         = 1'b0;
        cfg_index         = CFG_LEFT_SHIFT;
        cfg_wr_data       = '0;
        repeat (9) @(posedge aclk);
        aresetn <= 1'b1;

        // Directed opener under reset register values
        queue_event(load_event(8'hFF, 1'b0, 3'd7, 8'hFF, 1'b1));
        queue_event(load_event(8'h00, 1'b1, 3'd0, 8'h00, 1'b0));
        queue_event(load_event(8'h55, 1'b0, 3'd3, 8'hAA, 1'b0));
        queue_event(load_event(8'h55, 1'b1, 3'd5, 8'h0F, 1'b1));
        queue_event(load_event(8'h55, 1'b0, 3'd2, 8'h81, 1'b1));   // redefinition
        queue_event(key_event(OP_PRESS, 8'hFF));
        queue_event(key_event(OP_PRESS, 8'h77));                  // unmapped
        queue_event(row_event(8'h7F));
        queue_event(any_event(OP_READ));
        queue_event(key_event(OP_PRESS, 8'h00));                  // left shift
        queue_event(key_event(OP_PRESS, 8'h55));
        queue_event(key_event(OP_RELEASE, 8'h01));                // right shift
        queue_event(key_event(OP_PRESS, 8'h55));
        queue_event(key_event(OP_RELEASE, 8'h02));                // AltGr ignored
        queue_event(key_event(OP_RELEASE, 8'h55));                // oldest record
        queue_event(row_event(8'hFE));
        queue_event(any_event(OP_READ));
        queue_event(any_event(OP_CLEAR));
        queue_event(key_event(OP_RELEASE, 8'h55));                // stale record
        queue_event(key_event(OP_RELEASE, 8'h77));                // nothing held
        queue_event(row_event(8'hFF));
        queue_event(any_event(OP_READ));
        queue_event(key_event_t'({OP_SPARE_6, 29'h1FFF_FFFF}));
        queue_event(key_event_t'({OP_SPARE_7, 29'h0}));
        queue_event(row_event(8'h00));
        queue_event(any_event(OP_READ));
        while (stim_q.size() != 0)
            send_event(stim_q.pop_front());

        for (int p = 0; p < N_PHASES; p++) begin
            drain_results();
            apply_config(phase_setting(p));
            case (p)
                1:       begin tx_idle_pct = 82; rx_stall_pct = 0;  end
                2:       begin tx_idle_pct = 0;  rx_stall_pct = 82; end
                3, 5:    begin tx_idle_pct = 29; rx_stall_pct = 29; end
                default: begin tx_idle_pct = 0;  rx_stall_pct = 0;  end
            endcase
            foreach (key_pool[i]) key_pool[i] = 8'($urandom);
            // first phase: long result back-pressure while input keeps coming
            if (p == 0)
                rx_hold_req = 1'b1;
            phase_sent = 0;
            while (phase_sent < PHASE_ITEMS || stim_q.size() != 0) begin
                if (stim_q.size() == 0)
                    queue_random_burst();
                send_event(stim_q.pop_front());
                phase_sent++;
                if (p == 0 && phase_sent == 80)
                    drain_results();
            end
        end

        drain_results();
        repeat (8) @(posedge aclk);
        if (sb.expected_results.size() != 0) begin
            $display("%0t: %0d results never arrived", $time, sb.expected_results.size());
            sb.errors++;
        end
        $display("Run: %0d transactions in, %0d results checked (%0d hits, %0d list-full drops,",
                 sb.accepted, sb.checked, sb.n_found, sb.n_full);
        $display("  %0d non-zero reads); six register settings, idle and stall mixes, %0d mismatches",
                 sb.n_reads, sb.errors);
        if (sb.errors == 0)
            $display("TEST PASSED");
        else
            $display("TEST FAILED");
        $finish;
    end

endmodule : tb_key_event_matrix_scanner
